// ===== design/wfrs_pkg.sv =====
// Shared types, widths and constants of the weigh filter range stability unit.
// No dependencies; every other design file except wfrs_ram imports this package.
package wfrs_pkg;

    localparam int MASS_BITS  = 24;
    localparam int MAX_WINDOW = 64;
    localparam int RING_AW    = $clog2(MAX_WINDOW);
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = MASS_BITS + RING_AW;
    localparam int WIDE_W     = MASS_BITS + 2;
    localparam int CAP_W      = 23;
    localparam int DIVR_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int REG_WIN_W  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [DIVR_W-1:0]   ZERO_DIV_FIRST = DIVR_W'(4);
    localparam logic [DIVR_W-1:0]   ZERO_DIV_LATER = DIVR_W'(25);
    localparam logic [DIVR_W-1:0]   OVL_DIVS       = DIVR_W'(9);
    localparam logic [REG_WIN_W-1:0] WIN_RESET     = REG_WIN_W'(10);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(1000);

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_TARE   = 2'd2,
        FUNC_ZERO   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ZS_NONE   = 2'd0,
        ZS_REJECT = 2'd1,
        ZS_ACCEPT = 2'd2
    } zstat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN = 3'd0,
        CFG_CAPACITY   = 3'd1,
        CFG_THR_ONE    = 3'd2,
        CFG_THR_TWO    = 3'd3,
        CFG_DIV_ONE    = 3'd4,
        CFG_DIV_TWO    = 3'd5,
        CFG_DIV_THREE  = 3'd6,
        CFG_STAB_PER   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_AVG  = 2'd0,
        DIV_RND  = 2'd1
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RING_WR,
        ST_SUM,
        ST_AVG_WAIT,
        ST_NET,
        ST_RND_START,
        ST_RND_WAIT,
        ST_ROUND,
        ST_POST,
        ST_EXEC,
        ST_ZERO_CHK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic     cap;
        logic     ring_wr;
        logic     sum_run;
        logic     div_start;
        div_sel_t div_sel;
        logic     net_ld;
        logic     round_ld;
        logic     post_ld;
        logic     exec;
        logic     zero_ld;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  fault;
        logic  sum_done;
        logic  div_busy;
    } dp_stat_t;

endpackage

// ===== design/wfrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module wfrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/wfrs_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on wfrs_pkg for widths.
module wfrs_div import wfrs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              busy,
    output logic [SUM_W-1:0]  quot,
    output logic [DIVR_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]     quot_reg, quot_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[SUM_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            quot_next = {quot_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/wfrs_dp.sv =====
// Datapath: configuration registers, sample ring, accumulator, shared divider,
// tare/zero/stability state and the output payload register.
// Depends on wfrs_pkg, wfrs_ram and wfrs_div.
module wfrs_dp import wfrs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            in_func,
    input  logic [MASS_BITS-1:0]  in_mass,
    input  logic                  in_fault,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat,
    output logic [31:0]           out_data
);

    // configuration
    logic [REG_WIN_W-1:0] window_len_reg;
    logic [CAP_W-1:0]     capacity_reg, thr_one_reg, thr_two_reg;
    logic [DIVR_W-1:0]    div_one_reg, div_two_reg, div_three_reg;
    logic [PERIOD_W-1:0]  stab_period_reg;

    // captured item
    func_t                func_reg;
    logic [MASS_BITS-1:0] mass_reg;
    logic                 fault_reg;

    // filter and indicator state
    logic [RING_AW-1:0]    ring_idx_reg;
    logic [MAX_WINDOW-1:0] ring_valid_reg;
    logic [WIN_W-1:0]      rd_cnt_reg;
    logic                  pend_reg;
    logic                  rd_valid_reg;
    logic signed [SUM_W-1:0]     acc_reg;
    logic signed [WIDE_W-1:0]    net_reg;
    logic signed [MASS_BITS-1:0] tare_reg, cur_reg, last_reg;
    logic                  tare_flag_reg, first_zero_reg;
    logic [PERIOD_W-1:0]   timer_reg;
    logic [1:0]            range_reg;
    logic                  ovl_reg, stable_reg;
    zstat_t                zstat_reg;
    logic [31:0]           out_reg;

    logic [WIN_W-1:0]     w_eff;
    logic [WIN_W-1:0]     ring_nxt;
    logic                 rd_en;
    logic [MASS_BITS-1:0] ram_rdata;
    logic [SUM_W-1:0]     div_dividend;
    logic [DIVR_W-1:0]    div_divisor;
    logic                 div_busy;
    logic [SUM_W-1:0]     div_quot;
    logic [DIVR_W-1:0]    div_rem;
    logic [DIVR_W-1:0]    d_raw, d_eff;
    logic signed [WIDE_W-1:0] avg, net_calc, tare_w, cur_w, last_w;
    logic [WIDE_W-1:0]    net_abs, mag;
    logic signed [WIDE_W-1:0] rounded, sat_val;
    logic [1:0]           range_calc;
    logic signed [WIDE_W-1:0] gross, ovl_lim, d_w, hi_lim, lo_lim, zsum;
    logic [WIDE_W-1:0]    zabs;
    logic [DIVR_W-1:0]    zero_mult;
    logic [SUM_W-1:0]     zero_need;

    always_comb
    begin
        if (window_len_reg == '0)
            w_eff = WIN_W'(1);
        else if (WIN_W'(window_len_reg) > WIN_W'(MAX_WINDOW))
            w_eff = WIN_W'(MAX_WINDOW);
        else
            w_eff = WIN_W'(window_len_reg);
        ring_nxt = WIN_W'(ring_idx_reg) + 1'b1;
        rd_en    = cmd.sum_run && (rd_cnt_reg < w_eff);
    end

    wfrs_ram #(.WIDTH(MASS_BITS), .DEPTH(MAX_WINDOW)) u_ring (
        .clk   (clk),
        .we    (cmd.ring_wr),
        .waddr (ring_idx_reg),
        .wdata (mass_reg),
        .re    (rd_en),
        .raddr (rd_cnt_reg[RING_AW-1:0]),
        .rdata (ram_rdata)
    );

    // divider operand selection
    always_comb
    begin
        d_raw = (range_reg == 2'd1) ? div_one_reg :
                (range_reg == 2'd2) ? div_two_reg : div_three_reg;
        d_eff = (d_raw == '0) ? DIVR_W'(1) : d_raw;
        net_abs = net_reg[WIDE_W-1] ? WIDE_W'(-net_reg) : WIDE_W'(net_reg);
        unique case (cmd.div_sel)
            DIV_AVG:
            begin
                div_dividend = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
                div_divisor  = DIVR_W'(w_eff);
            end
            DIV_RND:
            begin
                div_dividend = SUM_W'(net_abs);
                div_divisor  = d_eff;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = DIVR_W'(1);
            end
        endcase
    end

    wfrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // arithmetic around the divider
    always_comb
    begin
        tare_w = WIDE_W'(tare_reg);
        cur_w  = WIDE_W'(cur_reg);
        last_w = WIDE_W'(last_reg);
        avg    = acc_reg[SUM_W-1] ? -$signed(div_quot[WIDE_W-1:0])
                                  : $signed(div_quot[WIDE_W-1:0]);
        net_calc = tare_flag_reg ? (avg - tare_w) : avg;
        if ((thr_two_reg != '0) && (net_calc > $signed(WIDE_W'(thr_two_reg))))
            range_calc = 2'd3;
        else if (((thr_one_reg != '0) || (thr_two_reg != '0)) &&
                 (net_calc > $signed(WIDE_W'(thr_one_reg))))
            range_calc = 2'd2;
        else
            range_calc = 2'd1;
        // quotient times d equals magnitude minus remainder
        mag = net_abs - WIDE_W'(div_rem);
        if ((d_eff > DIVR_W'(1)) && (div_rem >= (d_eff >> 1)))
            mag = mag + WIDE_W'(d_eff);
        rounded = net_reg[WIDE_W-1] ? -$signed(mag) : $signed(mag);
        if (rounded > $signed(WIDE_W'({1'b0, {(MASS_BITS-1){1'b1}}}))) 
            sat_val = $signed(WIDE_W'({1'b0, {(MASS_BITS-1){1'b1}}}));
        else if (rounded < -$signed(WIDE_W'({1'b1, {(MASS_BITS-1){1'b0}}})))
            sat_val = -$signed(WIDE_W'({1'b1, {(MASS_BITS-1){1'b0}}}));
        else
            sat_val = rounded;
        d_w     = $signed(WIDE_W'(d_eff));
        gross   = cur_w + tare_w;
        ovl_lim = $signed(WIDE_W'(capacity_reg)) + d_w * $signed(WIDE_W'(OVL_DIVS));
        hi_lim  = last_w + (d_w <<< 1);
        lo_lim  = last_w - (d_w <<< 1);
        zsum    = cur_w + tare_w;
        zabs    = zsum[WIDE_W-1] ? WIDE_W'(-zsum) : WIDE_W'(zsum);
        // capacity / k > |gross| holds exactly when capacity >= k * (|gross| + 1)
        zero_mult = first_zero_reg ? ZERO_DIV_LATER : ZERO_DIV_FIRST;
        zero_need = SUM_W'(zero_mult) * (SUM_W'(zabs) + SUM_W'(1));
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg  <= WIN_RESET;
            capacity_reg    <= '0;
            thr_one_reg     <= '0;
            thr_two_reg     <= '0;
            div_one_reg     <= DIVR_W'(1);
            div_two_reg     <= DIVR_W'(1);
            div_three_reg   <= DIVR_W'(1);
            stab_period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LEN: window_len_reg  <= cfg_data[REG_WIN_W-1:0];
                CFG_CAPACITY:   capacity_reg    <= cfg_data[CAP_W-1:0];
                CFG_THR_ONE:    thr_one_reg     <= cfg_data[CAP_W-1:0];
                CFG_THR_TWO:    thr_two_reg     <= cfg_data[CAP_W-1:0];
                CFG_DIV_ONE:    div_one_reg     <= cfg_data[DIVR_W-1:0];
                CFG_DIV_TWO:    div_two_reg     <= cfg_data[DIVR_W-1:0];
                CFG_DIV_THREE:  div_three_reg   <= cfg_data[DIVR_W-1:0];
                CFG_STAB_PER:   stab_period_reg <= cfg_data[PERIOD_W-1:0];
                default:        window_len_reg  <= window_len_reg;
            endcase
        end
    end

    // state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg       <= FUNC_SAMPLE;
            fault_reg      <= 1'b0;
            ring_idx_reg   <= '0;
            ring_valid_reg <= '0;
            rd_cnt_reg     <= '0;
            pend_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            net_reg        <= '0;
            tare_reg       <= '0;
            cur_reg        <= '0;
            last_reg       <= '0;
            tare_flag_reg  <= 1'b0;
            first_zero_reg <= 1'b0;
            timer_reg      <= '0;
            range_reg      <= 2'd1;
            ovl_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            zstat_reg      <= ZS_NONE;
            out_reg        <= '0;
        end
        else
        begin
            if (cmd.cap)
            begin
                func_reg  <= func_t'(in_func);
                fault_reg <= in_fault;
                zstat_reg <= ZS_NONE;
            end
            if (cmd.ring_wr)
            begin
                ring_valid_reg[ring_idx_reg] <= 1'b1;
                ring_idx_reg <= (ring_nxt >= w_eff) ? '0 : ring_nxt[RING_AW-1:0];
                rd_cnt_reg   <= '0;
                pend_reg     <= 1'b0;
                acc_reg      <= '0;
            end
            if (cmd.sum_run)
            begin
                pend_reg <= rd_en;
                if (rd_en)
                begin
                    rd_cnt_reg   <= rd_cnt_reg + 1'b1;
                    rd_valid_reg <= ring_valid_reg[rd_cnt_reg[RING_AW-1:0]];
                end
                if (pend_reg && rd_valid_reg)
                begin
                    acc_reg <= acc_reg + SUM_W'($signed(ram_rdata));
                end
            end
            if (cmd.net_ld)
            begin
                net_reg   <= net_calc;
                range_reg <= range_calc;
                if (!tare_flag_reg)
                    tare_reg <= '0;
            end
            if (cmd.round_ld)
            begin
                cur_reg <= sat_val[MASS_BITS-1:0];
            end
            if (cmd.post_ld)
            begin
                ovl_reg <= (gross > ovl_lim);
                if ((timer_reg == '0) && !fault_reg)
                begin
                    stable_reg <= (cur_w < hi_lim) && (cur_w > lo_lim);
                    last_reg   <= cur_reg;
                    timer_reg  <= stab_period_reg;
                end
            end
            if (cmd.exec && !fault_reg && (func_reg == FUNC_TARE))
            begin
                if (!tare_flag_reg)
                    tare_reg <= cur_reg;
                tare_flag_reg <= !tare_flag_reg;
            end
            if (cmd.exec && (func_reg == FUNC_TICK) && (timer_reg != '0))
            begin
                timer_reg <= timer_reg - 1'b1;
            end
            if (cmd.zero_ld)
            begin
                if (SUM_W'(capacity_reg) >= zero_need)
                begin
                    first_zero_reg <= 1'b1;
                    tare_reg       <= '0;
                    zstat_reg      <= ZS_ACCEPT;
                end
                else
                begin
                    zstat_reg <= ZS_REJECT;
                end
            end
            if (cmd.out_load)
            begin
                out_reg <= {zstat_reg, tare_flag_reg, (cur_reg == '0) && !fault_reg,
                            stable_reg, ovl_reg, range_reg, cur_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
            mass_reg <= in_mass;
    end

    assign stat.func     = func_reg;
    assign stat.fault    = fault_reg;
    assign stat.sum_done = cmd.sum_run && !rd_en && !pend_reg;
    assign stat.div_busy = div_busy;
    assign out_data      = out_reg;

endmodule

// ===== design/wfrs_ctrl.sv =====
// Controller state machine: sequences one item through the datapath and
// owns the input ready and output valid. Depends on wfrs_pkg.
module wfrs_ctrl import wfrs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] in_func,
    input  logic      in_fault,
    output logic      out_valid,
    input  logic      out_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_sel    = DIV_AVG;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap = 1'b1;
                    unique case (func_t'(in_func))
                        FUNC_SAMPLE: state_next = ST_RING_WR;
                        FUNC_ZERO:   state_next = in_fault ? ST_RESULT : ST_ZERO_CHK;
                        default:     state_next = ST_EXEC;
                    endcase
                end
            end
            ST_RING_WR:
            begin
                cmd.ring_wr = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (stat.sum_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_AVG;
                    state_next    = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT:
            begin
                cmd.div_sel = DIV_AVG;
                if (!stat.div_busy)
                    state_next = ST_NET;
            end
            ST_NET:
            begin
                cmd.div_sel = DIV_AVG;
                cmd.net_ld  = 1'b1;
                state_next  = ST_RND_START;
            end
            ST_RND_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_RND;
                state_next    = ST_RND_WAIT;
            end
            ST_RND_WAIT:
            begin
                cmd.div_sel = DIV_RND;
                if (!stat.div_busy)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.div_sel  = DIV_RND;
                cmd.round_ld = 1'b1;
                state_next   = ST_POST;
            end
            ST_POST:
            begin
                cmd.div_sel = DIV_RND;
                cmd.post_ld = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_ZERO_CHK:
            begin
                cmd.zero_ld = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/weigh_filter_range_stability_unit.sv =====
// Weighing indicator core: moving average, tare, three-range rounding, overload,
// stability and zero handling. Depends on wfrs_pkg, wfrs_ctrl, wfrs_dp.
// A sample reads its window from the ring one entry per cycle, then runs the shared divider
// twice; tick, tare and zero skip both, and a faulted zero goes straight to the result.
// Throughput: one item at a time; a waiting result does not block the next input beat.
// Reset: async, active low; clears control state; ring entries read as zero until written.
module weigh_filter_range_stability_unit import wfrs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [23:0] sample_mass, [24] sensor_fault
    input  logic [1:0]            s_tuser,   // [1:0] func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [23:0] shown_mass, [25:24] range_index,
                                             // [26] overload, [27] stable, [28] at_zero,
                                             // [29] tare_on, [31:30] zero_status
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    wfrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_fault  (s_tdata[MASS_BITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wfrs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_func   (s_tuser),
        .in_mass   (s_tdata[MASS_BITS-1:0]),
        .in_fault  (s_tdata[MASS_BITS]),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule

// ===== design/wfrs_checker.sv =====
// Port-level checks of the weigh filter range stability unit, bound to the top.
// Depends on wfrs_pkg and weigh_filter_range_stability_unit.
module wfrs_checker import wfrs_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:24] != 2'd0)
        else $error("range index zero");

    a_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[28] |-> m_tdata[23:0] == '0)
        else $error("at_zero with nonzero mass");

    a_zstat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] != 2'd3)
        else $error("undefined zero status");

endmodule

bind weigh_filter_range_stability_unit wfrs_checker u_wfrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_weigh_filter_range_stability_unit.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the weigh filter range stability unit: stream beats
// in, per-beat scale reading predicted and compared. Depends on wfrs_pkg and the RTL.
module tb_weigh_filter_range_stability_unit;
    import wfrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] mass;
        logic        fault;
    } scale_item_t;

    typedef struct packed {
        logic [1:0]  zstat;
        logic        tare_flag;
        logic        zero_flag;
        logic        stab;
        logic        ovl;
        logic [1:0]  range_idx;
        logic [23:0] shown;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;   // [23:0] sample_mass, [24] sensor_fault
    logic [1:0]  s_tuser = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [23:0] shown_mass, [25:24] range, [26] overload,
                                 // [27] stable, [28] at_zero, [29] tare_on, [31:30] zero_status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    weigh_filter_range_stability_unit u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    longint unsigned cfg_val [8];
    longint ring [64];
    int     ring_pos;
    longint tare_amt, shown_now, last_check;
    bit     tare_active, zero_done, ovl_bit, stab_bit;
    int     stab_count, range_now;

    scale_item_t pending_items[$];
    reading_t    expected_readings[$];
    int  error_count = 0;
    int  beats_in = 0, beats_out = 0, config_writes = 0;
    bit  idle_free = 1'b0;      // no idling on either side when set
    bit  hold_off = 1'b0;       // receiver long stall
    int  quiet_cycles = 0;

    function automatic longint clamp_mass(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic longint step_of(int r);
        longint d;
        d = (r == 1) ? cfg_val[CFG_DIV_ONE] : (r == 2) ? cfg_val[CFG_DIV_TWO]
                                                      : cfg_val[CFG_DIV_THREE];
        return (d == 0) ? 1 : d;
    endfunction

    function automatic longint round_to_step(longint v, longint d);
        longint a, q;
        a = (v < 0) ? -v : v;
        q = (a / d) * d;
        if (d > 1 && (a % d) >= d / 2) q += d;
        return (v < 0) ? -q : q;
    endfunction

    task automatic predictor_reset();
        cfg_val = '{10, 0, 0, 0, 1, 1, 1, 1000};
        foreach (ring[i]) ring[i] = 0;
        ring_pos = 0; tare_amt = 0; tare_active = 0; zero_done = 0;
        shown_now = 0; last_check = 0; stab_count = 0; range_now = 1;
        ovl_bit = 0; stab_bit = 0;
    endtask

    // Advance the scale model by one beat and return the reading it gives.
    function automatic reading_t scale_predict(scale_item_t it);
        reading_t rd;
        longint w, total, net, d, lim, g;
        zstat_t zs;
        zs = ZS_NONE;
        case (func_t'(it.func))
            FUNC_SAMPLE:
            begin
                w = cfg_val[CFG_WINDOW_LEN];
                if (w == 0) w = 1;
                if (w > 64) w = 64;
                ring[ring_pos] = longint'(signed'(it.mass));
                ring_pos++;
                if (ring_pos >= w) ring_pos = 0;
                total = 0;
                for (int i = 0; i < w; i++) total += ring[i];
                net = total / w;
                if (tare_active) net -= tare_amt;
                else tare_amt = 0;
                if (cfg_val[CFG_THR_TWO] != 0 && net > longint'(cfg_val[CFG_THR_TWO]))
                    range_now = 3;
                else if ((cfg_val[CFG_THR_ONE] != 0 || cfg_val[CFG_THR_TWO] != 0) &&
                         net > longint'(cfg_val[CFG_THR_ONE]))
                    range_now = 2;
                else
                    range_now = 1;
                d = step_of(range_now);
                shown_now = clamp_mass(round_to_step(net, d));
                ovl_bit = shown_now + tare_amt > longint'(cfg_val[CFG_CAPACITY]) + 9 * d;
                if (stab_count == 0 && !it.fault)
                begin
                    stab_bit = shown_now < last_check + 2 * d &&
                               shown_now > last_check - 2 * d;
                    last_check = shown_now;
                    stab_count = int'(cfg_val[CFG_STAB_PER]);
                end
            end
            FUNC_TICK:
                if (stab_count > 0) stab_count--;
            FUNC_TARE:
                if (!it.fault)
                begin
                    if (!tare_active) tare_amt = shown_now;
                    tare_active = !tare_active;
                end
            default:
                if (!it.fault)
                begin
                    lim = zero_done ? longint'(cfg_val[CFG_CAPACITY] / 25)
                                    : longint'(cfg_val[CFG_CAPACITY] / 4);
                    g = shown_now + tare_amt;
                    if (g < 0) g = -g;
                    if (lim > g)
                    begin
                        zero_done = 1; tare_amt = 0; zs = ZS_ACCEPT;
                    end
                    else
                        zs = ZS_REJECT;
                end
        endcase
        rd.shown = shown_now[23:0];
        rd.range_idx = range_now[1:0];
        rd.ovl = ovl_bit;
        rd.stab = stab_bit;
        rd.zero_flag = (shown_now == 0) && !it.fault;
        rd.tare_flag = tare_active;
        rd.zstat = zs;
        return rd;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_out, what, got, want);
    endtask

    // Driver: present the oldest pending item; idle at random unless free-running.
    always @(posedge clk)
    begin
        scale_item_t it;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                beats_in++;
                void'(pending_items.pop_front());
            end
            if ((!s_tvalid || s_tready) && pending_items.size() > 0 &&
                (idle_free || $urandom_range(99) >= 34))
            begin
                it = (s_tvalid && s_tready) ? pending_items[0] : pending_items[0];
                s_tvalid <= 1'b1;
                s_tuser  <= it.func;
                s_tdata  <= {7'b0, it.fault, it.mass};
            end
            else if (!s_tvalid || s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // Predict at acceptance so model order follows beat order.
    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            expected_readings.push_back(scale_predict(scale_item_t'({s_tuser, s_tdata[23:0],
                                                                      s_tdata[24]})));

    // Receiver ready: random stalls, plus a long hold-off on request.
    always @(posedge clk)
        if (rst_n)
            m_tready <= !hold_off && (idle_free || $urandom_range(99) >= 34);

    // Monitor: compare each accepted reading against the oldest expectation.
    always @(posedge clk)
    begin
        reading_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            got = m_tdata;
            if (expected_readings.size() == 0)
                report_mismatch("unexpected beat", m_tdata, 0);
            else
            begin
                want = expected_readings.pop_front();
                if (got.shown != want.shown)
                    report_mismatch("shown_mass", signed'(got.shown), signed'(want.shown));
                if (got.range_idx != want.range_idx)
                    report_mismatch("range_index", got.range_idx, want.range_idx);
                if (got.ovl != want.ovl) report_mismatch("overload", got.ovl, want.ovl);
                if (got.stab != want.stab) report_mismatch("stable", got.stab, want.stab);
                if (got.zero_flag != want.zero_flag)
                    report_mismatch("at_zero", got.zero_flag, want.zero_flag);
                if (got.tare_flag != want.tare_flag)
                    report_mismatch("tare_on", got.tare_flag, want.tare_flag);
                if (got.zstat != want.zstat)
                    report_mismatch("zero_status", got.zstat, want.zstat);
            end
        end
    end

    // Watchdog: count cycles where no beat moves on any channel and no receiver hold-off is active.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic scale_item_t make_item(func_t f, longint m, bit flt);
        scale_item_t it;
        it.func = f;
        it.mass = m[23:0];
        it.fault = flt;
        return it;
    endfunction

    // Wait for the block to drain before going on.
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_readings.size() > 0)
            @(posedge clk);
        repeat (2 * 64 + 100) @(posedge clk);
    endtask

    // Write one register through the config channel and mirror it.
    task automatic write_reg(cfg_idx_t idx, longint unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_LEN: cfg_val[idx] = val & 'h7F;
            CFG_DIV_ONE, CFG_DIV_TWO, CFG_DIV_THREE: cfg_val[idx] = val & 'hFF;
            CFG_STAB_PER:   cfg_val[idx] = val & 'hFFFF;
            default:        cfg_val[idx] = val & 'h7FFFFF;
        endcase
        config_writes++;
    endtask

    // Random item: mostly samples near a working level, with ticks, tare and zero.
    function automatic scale_item_t random_item(longint level);
        int pick;
        longint m;
        pick = $urandom_range(99);
        m = level + $signed($urandom_range(400)) - 200;
        if ($urandom_range(19) == 0) m = $signed($urandom);
        if (pick < 55) return make_item(FUNC_SAMPLE, m, $urandom_range(9) == 0);
        if (pick < 75) return make_item(FUNC_TICK, $signed($urandom), 1'($urandom_range(1)));
        if (pick < 87) return make_item(FUNC_TARE, $signed($urandom), $urandom_range(7) == 0);
        return make_item(FUNC_ZERO, $signed($urandom), $urandom_range(7) == 0);
    endfunction

    // One phase: program a setting, then send a batch of random items.
    task automatic run_phase(longint unsigned win, longint unsigned cap, longint unsigned t1,
                             longint unsigned t2, longint unsigned d1, longint unsigned d2,
                             longint unsigned d3, longint unsigned per, int count,
                             longint level);
        wait_drained();
        write_reg(CFG_WINDOW_LEN, win);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_THR_ONE, t1);
        write_reg(CFG_THR_TWO, t2);
        write_reg(CFG_DIV_ONE, d1);
        write_reg(CFG_DIV_TWO, d2);
        write_reg(CFG_DIV_THREE, d3);
        write_reg(CFG_STAB_PER, per);
        for (int i = 0; i < count; i++) pending_items.push_back(random_item(level));
    endtask

    initial
    begin
        predictor_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes, every kind, fault gating,
        // tare toggling, first and later zero limits.
        write_reg(CFG_CAPACITY, 'd40000);
        write_reg(CFG_THR_ONE, 'd1000);
        write_reg(CFG_THR_TWO, 'd5000);
        write_reg(CFG_DIV_TWO, 'd0);      // a zero division behaves as one
        write_reg(CFG_DIV_THREE, 'd5);
        write_reg(CFG_STAB_PER, 'd2);
        pending_items.push_back(make_item(FUNC_ZERO, 0, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, 8388607, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, -8388608, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, 'hFFFFFF, 1));
        pending_items.push_back(make_item(FUNC_TICK, 'h555555, 1));
        pending_items.push_back(make_item(FUNC_TICK, 'hAAAAAA, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, 30000, 0));
        pending_items.push_back(make_item(FUNC_TARE, 0, 1));
        pending_items.push_back(make_item(FUNC_TARE, 0, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, 31000, 0));
        pending_items.push_back(make_item(FUNC_ZERO, 0, 1));
        pending_items.push_back(make_item(FUNC_ZERO, 0, 0));
        pending_items.push_back(make_item(FUNC_TARE, 0, 0));
        for (int i = 0; i < 10; i++) pending_items.push_back(make_item(FUNC_SAMPLE, 0, 0));
        pending_items.push_back(make_item(FUNC_ZERO, 0, 0));
        pending_items.push_back(make_item(FUNC_SAMPLE, 5000, 0));

        // Window extremes, zero window, division halves and saturation.
        run_phase(1, 8388607, 0, 0, 255, 255, 255, 0, 70, 0);
        run_phase(0, 100, 50, 0, 2, 3, 1, 1, 60, 60);
        idle_free = 1'b1;
        run_phase(64, 2000, 100, 100, 7, 8, 9, 3, 70, 150);
        idle_free = 1'b0;
        run_phase(127, 0, 8388607, 8388607, 4, 1, 1, 65535, 40, -300);
        run_phase(3, 1000000, 2000, 6000, 1, 10, 20, 5, 100, 4000);

        // Long receiver hold-off with the sender still offering beats.
        wait_drained();
        for (int i = 0; i < 40; i++) pending_items.push_back(random_item(0));
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;

        run_phase(5, 50000, 500, 3000, 3, 6, 12, 4, 150, 1000);

        wait_drained();
        $display("covered %0d input beats, %0d readings, %0d register writes",
                 beats_in, beats_out, config_writes);
        $display("settings spanned windows 1..64 plus out-of-range, divisions 0..255");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
